// ===== hw/rtl/vtp_pkg.sv =====
// Shared types, codes and constants of the virtual timer pool.
package vtp_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int TICK_MS = 10;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int PMS_W = 16;
	localparam int TICKS_W = 13;
	localparam int NUM_W = 8;
	localparam int SLOT_W = 3;
	localparam int KIND_W = 3;
	localparam logic [TICKS_W-1:0] TICKS_MAX = 13'd8191;

	// period_ms / TICK_MS as multiply by rounded-up reciprocal, exact for 16-bit inputs
	localparam int DIV_SH = PMS_W + $clog2(TICK_MS);
	localparam int DIV_RECIP = ((1 << DIV_SH) + TICK_MS - 1) / TICK_MS;
	localparam int RECIP_W = DIV_SH - $clog2(TICK_MS) + 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_STOP  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_STARTED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STOPPED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REFUSED  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TICKDONE = 3'd4;

	typedef enum logic [2:0] {
		CMD_START,
		CMD_STOP,
		CMD_TICK,
		CMD_TICK_NOP,
		CMD_REFUSE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [TICKS_W-1:0]  ticks;
		logic                rpt;
		logic [NUM_W-1:0]    number;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} back_state_t;

endpackage

// ===== hw/rtl/virtual_timer_pool.sv =====
// Top level of the virtual timer pool: front end, command queue and sequencer.
//
// A pool of NUM_TIMERS (8) software timers advanced by a base tick. Each input
// item is a start, stop or tick request; the front end classifies it and converts
// the start period from ms to ticks (period_ms / TICK_MS, capped at 8191), then
// drops a command into a two-entry queue, so input items are still taken while it
// has room, even as the sequencer works or the result side stalls. Start claims the
// highest free slot (refused for zero period, no handler or a full pool), stop
// frees an active slot (refused if out of range or idle), action 3 is refused.
// Start, stop and refuse give one result each. A tick from source 0 walks the
// slots one per cycle, pausing while a firing slot waits for the result register,
// and reports each expiry, then a closing tick_done with tlast set. Ticks from
// other sources only answer tick_done. Every result but a tick's expiries
// carries tlast.
module virtual_timer_pool (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // period_ms[15:0], repeat_req[16], has_handler[17],
	                               // timer_number[25:18], zero pad above
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot[2:0], period_ticks[15:3]
	output logic [2:0]  m_tuser,   // result_kind[2:0]
	output logic        m_tlast    // last result of the input item
);
	import vtp_pkg::*;

	cmd_t front_cmd;
	cmd_t q_head;
	logic q_full;
	logic q_avail;
	logic q_pop;
	logic push;

	logic [SLOT_W-1:0]  out_slot;
	logic [TICKS_W-1:0] out_ticks;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	vtp_front u_front (
		.action       (s_tuser),
		.period_ms    (s_tdata[15:0]),
		.repeat_req   (s_tdata[16]),
		.has_handler  (s_tdata[17]),
		.timer_number (s_tdata[25:18]),
		.cmd          (front_cmd)
	);

	vtp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.avail    (q_avail),
		.pop      (q_pop),
		.head     (q_head)
	);

	vtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_avail),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_slot  (out_slot),
		.out_ticks (out_ticks),
		.out_last  (m_tlast)
	);

	assign m_tdata = {out_ticks, out_slot};

endmodule

// ===== hw/rtl/vtp_front.sv =====
// Front end: classifies input items into commands and converts ms to ticks.
module vtp_front (
	input  logic [1:0]               action,
	input  logic [15:0]              period_ms,
	input  logic                     repeat_req,
	input  logic                     has_handler,
	input  logic [7:0]               timer_number,
	output vtp_pkg::cmd_t            cmd
);
	import vtp_pkg::*;

	logic [RECIP_W-1:0]       recip;
	logic [PMS_W+RECIP_W-1:0] prod;
	logic [PMS_W-1:0]         quot;
	logic [TICKS_W-1:0]       ticks;

	assign recip = RECIP_W'(DIV_RECIP);
	assign prod  = {{RECIP_W{1'b0}}, period_ms} * {{PMS_W{1'b0}}, recip};
	assign quot  = PMS_W'(prod >> DIV_SH);
	assign ticks = (quot > PMS_W'(TICKS_MAX)) ? TICKS_MAX : TICKS_W'(quot);

	always_comb begin
		cmd.ticks  = ticks;
		cmd.rpt    = repeat_req;
		cmd.number = timer_number;
		case (action)
			ACT_START: begin
				// zero period or no handler never reaches the pool
				cmd.kind = (period_ms == '0 || !has_handler) ? CMD_REFUSE : CMD_START;
			end
			ACT_STOP: begin
				cmd.kind = CMD_STOP;
			end
			ACT_TICK: begin
				// only source 0 drives the timers
				cmd.kind = (timer_number == '0) ? CMD_TICK : CMD_TICK_NOP;
			end
			default: begin
				cmd.kind = CMD_REFUSE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/vtp_queue.sv =====
// Short command queue between front end and sequencer.
module vtp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vtp_pkg::cmd_t  push_cmd,
	output logic           full,
	output logic           avail,
	input  logic           pop,
	output vtp_pkg::cmd_t  head
);
	import vtp_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hw/rtl/vtp_back.sv =====
// Sequencer: owns the timer slots, runs commands and drives the result register.
module vtp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_avail,
	input  vtp_pkg::cmd_t                 q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vtp_pkg::KIND_W-1:0]    out_kind,
	output logic [vtp_pkg::SLOT_W-1:0]    out_slot,
	output logic [vtp_pkg::TICKS_W-1:0]   out_ticks,
	output logic                          out_last
);
	import vtp_pkg::*;

	back_state_t         state_q, state_d;
	logic [IDX_W-1:0]    idx_q, idx_d;

	logic                active_q  [NUM_TIMERS];
	logic                repeats_q [NUM_TIMERS];
	logic [TICKS_W-1:0]  period_q  [NUM_TIMERS];
	logic [TICKS_W-1:0]  count_q   [NUM_TIMERS];

	logic                valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [TICKS_W-1:0]  ticks_q;
	logic                last_q;

	logic                out_free;
	logic                ld;
	logic [KIND_W-1:0]   ld_kind;
	logic [SLOT_W-1:0]   ld_slot;
	logic [TICKS_W-1:0]  ld_ticks;
	logic                ld_last;

	logic                free_found;
	logic [IDX_W-1:0]    free_idx;
	logic                stop_ok;
	logic [IDX_W-1:0]    stop_idx;
	logic [TICKS_W-1:0]  cnt_new;
	logic                fire;

	logic                start_we;
	logic                clr_en;
	logic [IDX_W-1:0]    clr_idx;
	logic                cnt_we;
	logic [TICKS_W-1:0]  cnt_val;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_slot  = slot_q;
	assign out_ticks = ticks_q;
	assign out_last  = last_q;

	// highest-numbered free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign stop_idx = IDX_W'(q_head.number);
	assign stop_ok  = (q_head.number < NUM_W'(NUM_TIMERS)) && active_q[stop_idx];
	assign cnt_new  = (count_q[idx_q] < TICKS_MAX) ? count_q[idx_q] + 1'b1 : count_q[idx_q];
	assign fire     = (cnt_new >= period_q[idx_q]);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		q_pop    = 1'b0;
		ld       = 1'b0;
		ld_kind  = KIND_REFUSED;
		ld_slot  = '0;
		ld_ticks = '0;
		ld_last  = 1'b1;
		start_we = 1'b0;
		clr_en   = 1'b0;
		clr_idx  = idx_q;
		cnt_we   = 1'b0;
		cnt_val  = cnt_new;
		case (state_q)
			ST_IDLE: begin
				if (q_avail && out_free) begin
					q_pop = 1'b1;
					case (q_head.kind)
						CMD_START: begin
							ld = 1'b1;
							if (free_found) begin
								start_we = 1'b1;
								ld_kind  = KIND_STARTED;
								ld_slot  = SLOT_W'(free_idx);
							end
						end
						CMD_STOP: begin
							ld = 1'b1;
							if (stop_ok) begin
								clr_en  = 1'b1;
								clr_idx = stop_idx;
								ld_kind = KIND_STOPPED;
							end
						end
						CMD_TICK: begin
							state_d = ST_SCAN;
							idx_d   = '0;
						end
						CMD_TICK_NOP: begin
							ld      = 1'b1;
							ld_kind = KIND_TICKDONE;
						end
						default: begin
							ld = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// one slot per cycle; a firing slot waits for the result register
				if (!active_q[idx_q] || !fire || out_free) begin
					if (active_q[idx_q]) begin
						if (fire) begin
							ld       = 1'b1;
							ld_kind  = KIND_EXPIRED;
							ld_slot  = SLOT_W'(idx_q);
							ld_ticks = period_q[idx_q];
							ld_last  = 1'b0;
							if (repeats_q[idx_q]) begin
								cnt_we  = 1'b1;
								cnt_val = '0;
							end else begin
								clr_en = 1'b1;
							end
						end else begin
							cnt_we = 1'b1;
						end
					end
					if (idx_q == IDX_W'(NUM_TIMERS - 1)) begin
						state_d = ST_DONE;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = KIND_TICKDONE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				idx_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			valid_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				active_q[i]  <= 1'b0;
				repeats_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (ld) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (start_we) begin
				active_q[free_idx]  <= 1'b1;
				repeats_q[free_idx] <= q_head.rpt;
			end
			if (clr_en) begin
				active_q[clr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			kind_q  <= ld_kind;
			slot_q  <= ld_slot;
			ticks_q <= ld_ticks;
			last_q  <= ld_last;
		end
		if (start_we) begin
			period_q[free_idx] <= q_head.ticks;
			count_q[free_idx]  <= '0;
		end
		if (cnt_we) begin
			count_q[idx_q] <= cnt_val;
		end
	end

	// no command leaves the queue while a tick is being worked through
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !q_pop)
		else $error("queue popped during tick scan");

	// the scan index rests at zero between ticks
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("scan index not parked");

	// a started slot is active on the next cycle
	a_start_sets: assert property (@(posedge clk) disable iff (!arst_n)
		start_we |=> active_q[$past(free_idx)])
		else $error("started slot not active");

	// an expiry is never the closing result of a tick
	a_exp_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_EXPIRED) |-> !last_q)
		else $error("expiry flagged as last");

endmodule

// ===== test/virtual_timer_pool_tb.sv =====
// Self-checking testbench of the virtual timer pool: directed table, then random traffic.
`timescale 1ns / 1ps

module virtual_timer_pool_tb;
	import vtp_pkg::*;

	// Action code with no meaning in the block; it must be answered with refused.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// Tick source that advances the pool; any other source only gets tick_done.
	localparam logic [NUM_W-1:0] SRC_BASE = 8'd0;
	localparam logic [NUM_W-1:0] NO_SOURCE = 8'hFF;

	localparam int RANDOM_ITEMS = 255;
	localparam int HOLD_CYCLES = 150;     // long receiver hold-off
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;

	// One row of input: the item fields plus, where it is obvious, the expected result.
	typedef struct {
		logic [1:0]         act;
		logic [PMS_W-1:0]   pms;
		logic               rpt;
		logic               hnd;
		logic [NUM_W-1:0]   num;
		bit                 typed;
		logic [KIND_W-1:0]  t_kind;
		logic [SLOT_W-1:0]  t_slot;
	} stim_row_t;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [SLOT_W-1:0]  slot;
		logic [TICKS_W-1:0] ticks;
		logic               last;
	} timer_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;   // period_ms[15:0], repeat_req[16], has_handler[17],
	                              // timer_number[25:18], zero pad above
	logic [1:0]        s_tuser;   // action[1:0]
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;   // slot[2:0], period_ticks[15:3]
	logic [2:0]        m_tuser;   // result_kind[2:0]
	logic              m_tlast;

	virtual_timer_pool DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Our own copy of the pool state.
	bit                 pool_active [NUM_TIMERS];
	bit                 pool_repeats[NUM_TIMERS];
	logic [NUM_W-1:0]   pool_source [NUM_TIMERS];
	logic [TICKS_W-1:0] pool_period [NUM_TIMERS];
	logic [TICKS_W-1:0] pool_count  [NUM_TIMERS];

	timer_result_t step_out[$];      // results of the item just accepted
	timer_result_t due_results[$];   // results still owed by the block
	stim_row_t     plan[$];          // directed table

	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic timer_result_t make_result(logic [KIND_W-1:0] kind,
			logic [SLOT_W-1:0] slot, logic [TICKS_W-1:0] ticks, logic last);
		timer_result_t r;
		r.kind = kind;
		r.slot = slot;
		r.ticks = ticks;
		r.last = last;
		return r;
	endfunction

	// Predictor: applies one accepted item to the pool copy, leaves its results in step_out.
	function automatic void advance_pool(stim_row_t it);
		int free_slot;
		int ticks;
		step_out.delete();
		case (it.act)
			ACT_START: begin
				free_slot = -1;
				for (int i = 0; i < NUM_TIMERS; i++)
					if (!pool_active[i])
						free_slot = i;
				if (it.pms == 0 || !it.hnd || free_slot < 0) begin
					step_out.push_back(make_result(KIND_REFUSED, 0, 0, 1'b1));
				end else begin
					ticks = int'(it.pms) / TICK_MS;
					if (ticks > int'(TICKS_MAX))
						ticks = int'(TICKS_MAX);
					pool_active[free_slot] = 1'b1;
					pool_repeats[free_slot] = it.rpt;
					pool_source[free_slot] = SRC_BASE;
					pool_period[free_slot] = TICKS_W'(ticks);
					pool_count[free_slot] = '0;
					step_out.push_back(make_result(KIND_STARTED, SLOT_W'(free_slot), 0, 1'b1));
				end
			end
			ACT_STOP: begin
				if (it.num >= NUM_TIMERS || !pool_active[it.num[IDX_W-1:0]]) begin
					step_out.push_back(make_result(KIND_REFUSED, 0, 0, 1'b1));
				end else begin
					pool_active[it.num[IDX_W-1:0]] = 1'b0;
					pool_source[it.num[IDX_W-1:0]] = NO_SOURCE;
					step_out.push_back(make_result(KIND_STOPPED, 0, 0, 1'b1));
				end
			end
			ACT_TICK: begin
				// slot order, lowest first; only timers listening to this source move
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (!pool_active[i] || pool_source[i] != it.num)
						continue;
					if (pool_count[i] < TICKS_MAX)
						pool_count[i]++;
					if (pool_count[i] >= pool_period[i]) begin
						if (pool_repeats[i]) begin
							pool_count[i] = '0;
						end else begin
							pool_active[i] = 1'b0;
							pool_source[i] = NO_SOURCE;
						end
						step_out.push_back(make_result(KIND_EXPIRED, SLOT_W'(i),
							pool_period[i], 1'b0));
					end
				end
				step_out.push_back(make_result(KIND_TICKDONE, 0, 0, 1'b1));
			end
			default: begin
				step_out.push_back(make_result(KIND_REFUSED, 0, 0, 1'b1));
			end
		endcase
	endfunction

	task automatic row(logic [1:0] act, logic [PMS_W-1:0] pms, logic rpt, logic hnd,
			logic [NUM_W-1:0] num, bit typed, logic [KIND_W-1:0] t_kind,
			logic [SLOT_W-1:0] t_slot);
		stim_row_t r;
		r.act = act;
		r.pms = pms;
		r.rpt = rpt;
		r.hnd = hnd;
		r.num = num;
		r.typed = typed;
		r.t_kind = t_kind;
		r.t_slot = t_slot;
		plan.push_back(r);
	endtask

	// Offer one item from a falling edge, hold it until taken, return at the next falling edge.
	task automatic offer(stim_row_t it);
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, it.num, it.hnd, it.rpt, it.pms};
		s_tuser <= it.act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_pool(it);
		if (it.typed) begin
			// typed rows always give a single result with no period
			due_results.push_back(make_result(it.t_kind, it.t_slot, 0, 1'b1));
		end else begin
			foreach (step_out[k])
				due_results.push_back(step_out[k]);
		end
		@(negedge clk);
	endtask

	// Sender pacing: bursts of random length, random gaps, some bursts back to back.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// Stimulus: reset, directed table, random part, drain, verdict.
	initial begin : sender
		stim_row_t it;
		int pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			pool_active[i] = 1'b0;
			pool_repeats[i] = 1'b0;
			pool_source[i] = NO_SOURCE;
			pool_period[i] = '0;
			pool_count[i] = '0;
		end

		// empty pool and the refusals
		row(ACT_TICK,  16'd0,     0, 0, SRC_BASE, 1, KIND_TICKDONE, 0);
		row(ACT_STOP,  16'd0,     0, 0, 8'd0,     1, KIND_REFUSED, 0);
		row(ACT_STOP,  16'd0,     0, 0, 8'hFF,    1, KIND_REFUSED, 0);
		row(ACT_START, 16'd0,     1, 1, 8'd0,     1, KIND_REFUSED, 0);   // zero period
		row(ACT_START, 16'd100,   1, 0, 8'd0,     1, KIND_REFUSED, 0);   // no handler
		row(ACT_UNUSED, 16'hFFFF, 1, 1, 8'hFF,    1, KIND_REFUSED, 0);
		// fill from the top slot down: longest period, then short ones of 0, 1 and 2 ticks
		row(ACT_START, 16'hFFFF,  1, 1, 8'hFF,    1, KIND_STARTED, 7);
		row(ACT_START, 16'd5,     1, 1, 8'd0,     1, KIND_STARTED, 6);
		row(ACT_START, 16'd9,     0, 1, 8'd0,     1, KIND_STARTED, 5);
		row(ACT_START, 16'd10,    0, 1, 8'd0,     1, KIND_STARTED, 4);
		row(ACT_START, 16'd20,    1, 1, 8'd0,     1, KIND_STARTED, 3);
		row(ACT_TICK,  16'd0,     0, 0, 8'd1,     1, KIND_TICKDONE, 0);  // foreign source
		row(ACT_TICK,  16'd0,     0, 0, SRC_BASE, 0, KIND_STARTED, 0);
		row(ACT_TICK,  16'd0,     0, 0, SRC_BASE, 0, KIND_STARTED, 0);
		// five free slots left: fill them, the sixth start finds the pool full
		row(ACT_START, 16'd30,    0, 1, 8'd0,     0, KIND_STARTED, 0);
		row(ACT_START, 16'd40,    1, 1, 8'd0,     0, KIND_STARTED, 0);
		row(ACT_START, 16'd50,    0, 1, 8'd0,     0, KIND_STARTED, 0);
		row(ACT_START, 16'd60,    1, 1, 8'd0,     0, KIND_STARTED, 0);
		row(ACT_START, 16'd70,    0, 1, 8'd0,     0, KIND_STARTED, 0);
		row(ACT_START, 16'd80,    1, 1, 8'd0,     1, KIND_REFUSED, 0);
		row(ACT_TICK,  16'd0,     0, 0, SRC_BASE, 0, KIND_STARTED, 0);
		row(ACT_STOP,  16'd0,     0, 0, 8'd7,     1, KIND_STOPPED, 0);
		row(ACT_STOP,  16'd0,     0, 0, 8'd7,     1, KIND_REFUSED, 0);   // already idle
		row(ACT_STOP,  16'd0,     0, 0, 8'd8,     1, KIND_REFUSED, 0);   // out of range
		row(ACT_TICK,  16'd0,     0, 0, 8'hFF,    1, KIND_TICKDONE, 0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			offer(plan[i]);
			pace();
		end

		// Random part: mostly small periods so timers expire often, ticks mostly from
		// the base source; full-range values now and then to reach every bit.
		repeat (RANDOM_ITEMS) begin
			it.typed = 1'b0;
			it.t_kind = KIND_STARTED;
			it.t_slot = '0;
			it.rpt = 1'($urandom_range(0, 1));
			it.hnd = ($urandom_range(0, 9) != 0);
			it.num = NUM_W'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			it.act = (pick < 30) ? ACT_START : (pick < 55) ? ACT_STOP :
				(pick < 95) ? ACT_TICK : ACT_UNUSED;
			pick = $urandom_range(0, 99);
			if (pick < 50)
				it.pms = PMS_W'($urandom_range(10, 80));
			else if (pick < 65)
				it.pms = PMS_W'($urandom_range(1, 9));
			else if (pick < 75)
				it.pms = '0;
			else if (pick < 90)
				it.pms = PMS_W'($urandom_range(0, 65535));
			else
				it.pms = PMS_W'($urandom_range(80, 300));
			if (it.act == ACT_STOP && $urandom_range(0, 4) != 0)
				it.num = NUM_W'($urandom_range(0, NUM_TIMERS - 1));
			if (it.act == ACT_TICK && $urandom_range(0, 4) != 0)
				it.num = SRC_BASE;
			offer(it);
			pace();
		end
		s_tvalid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: changing stall patterns, plus one long hold-off that backs up the block.
	initial begin : receiver
		int rx_cycles;
		int hold_at;
		int seg;
		int mode;
		int stall_left;
		m_tready = 1'b0;
		rx_cycles = 0;
		seg = 0;
		mode = 0;
		stall_left = 0;
		hold_at = $urandom_range(300, 700);
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles == hold_at) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (seg == 0) begin
				seg = $urandom_range(10, 60);
				mode = $urandom_range(0, 3);
			end
			seg--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_cycles % 4 == 0);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						m_tready <= 1'b0;
					end else begin
						if ($urandom_range(0, 9) < 3)
							stall_left = $urandom_range(1, 8);
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Compare every accepted result with the oldest one owed.
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d ticks %0d last %0d",
					m_tuser, m_tdata[2:0], m_tdata[15:3], m_tlast);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (m_tuser !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
					fail_count++;
				end
				if (m_tdata[2:0] !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, m_tdata[2:0]);
					fail_count++;
				end
				if (m_tdata[15:3] !== want.ticks) begin
					$error("period_ticks: expected %0d, got %0d", want.ticks, m_tdata[15:3]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

// ===== files.f =====
hw/rtl/vtp_pkg.sv
hw/rtl/vtp_front.sv
hw/rtl/vtp_queue.sv
hw/rtl/vtp_back.sv
hw/rtl/virtual_timer_pool.sv
test/virtual_timer_pool_tb.sv
